// ----- rtl/core/temporal_three_frame_denoise_core_macros.svh -----
// Assertion macros for the denoise core checker
`ifndef TEMPORAL_THREE_FRAME_DENOISE_CORE_MACROS_SVH
`define TEMPORAL_THREE_FRAME_DENOISE_CORE_MACROS_SVH

// Check on i_clk, hold off while in reset
`define TTFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check on i_clk, also during reset
`define TTFD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/ttfd_pkg.sv -----
// Shared types, constants and arithmetic for the temporal denoise core
`timescale 1ns / 1ps

package ttfd_pkg;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 17;
    localparam int SUM_W   = 10;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    localparam logic [CFG_W-1:0] FRAME_BYTES_RESET = 17'd65536;
    localparam logic             REG_FRAME_BYTES   = 1'b0;

    localparam logic [10:0] RECIP3 = 11'd683;

    typedef logic [PIX_W-1:0] t_pixel;
    typedef logic [SUM_W-1:0] t_sum;

    // floor(sum / 3) for sum up to 765 via reciprocal multiply
    function automatic t_pixel div3(input t_sum sum);
        logic [20:0] prod;
        begin
            prod = {11'd0, sum} * {10'd0, RECIP3};
            return prod[18:11];
        end
    endfunction

endpackage

// ----- rtl/core/temporal_three_frame_denoise_core.sv -----
// Top level: recursive three-frame temporal average over a byte stream
`timescale 1ns / 1ps
// An accepted beat passes the memory read register, then the output register, to o_valid.
// Throughput: 1 beat per cycle unless i_ready stalls; read and write-back use a port each.
// Back-to-back hits on one address are forwarded from the write-back stage.
// Reset (synchronous, active low): clears position, slot select, pipeline valids and sets
// frame_bytes to 65536; the frame store reads as zero above a fill mark, no clearing pass.
module temporal_three_frame_denoise_core #(
    parameter int MAX_FRAME_BYTES = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ttfd_pkg::PIX_W-1:0]    i_pixel_in,
    input  logic                          i_frame_start,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ttfd_pkg::PIX_W-1:0]    o_pixel_out,
    output logic                          o_frame_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ttfd_pkg::PADDR_W-1:0]  paddr,
    input  logic [ttfd_pkg::DATA_W-1:0]   pwdata,
    output logic [ttfd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int PW = $clog2(MAX_FRAME_BYTES);
    localparam int CW = (PW + 1 > ttfd_pkg::CFG_W) ? PW + 1 : ttfd_pkg::CFG_W;
    localparam logic [CW-1:0] MAX_N = CW'(MAX_FRAME_BYTES);
    localparam int WW = 2 * ttfd_pkg::PIX_W;

    logic [WW-1:0] mem [MAX_FRAME_BYTES];

    logic [ttfd_pkg::CFG_W-1:0] r_frame_bytes;
    logic [PW-1:0]              r_byte_pos;
    logic                       r_newest;
    logic [PW:0]                r_fill;

    logic                       r_s1_valid;
    logic [PW-1:0]              r_s1_addr;
    ttfd_pkg::t_pixel           r_s1_pix;
    logic                       r_s1_last;
    logic                       r_s1_older;
    logic                       r_s1_zero;
    logic                       r_s1_fwd;
    logic [WW-1:0]              r_s1_fwd_word;
    logic [WW-1:0]              r_rdata;

    logic                       r_out_valid;
    ttfd_pkg::t_pixel           r_pixel_out;
    logic                       r_frame_last;

    logic                       cfg_wr;
    logic                       in_acc;
    logic                       s1_move;
    logic [PW-1:0]              pos;
    logic [CW-1:0]              cfg_x;
    logic [CW-1:0]              n_eff;
    logic                       last;
    logic [WW-1:0]              cur_word;
    ttfd_pkg::t_sum             sum;
    ttfd_pkg::t_pixel           avg;
    logic [WW-1:0]              wr_word;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready &&
                     (paddr[2] == ttfd_pkg::REG_FRAME_BYTES);
    assign prdata  = (paddr[2] == ttfd_pkg::REG_FRAME_BYTES) ?
                     {{(ttfd_pkg::DATA_W - ttfd_pkg::CFG_W){1'b0}}, r_frame_bytes} : '0;

    assign s1_move = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_move;
    assign in_acc  = i_valid && o_ready;

    always_comb begin
        pos   = i_frame_start ? '0 : r_byte_pos;
        cfg_x = CW'(r_frame_bytes);
        if (cfg_x == '0) begin
            n_eff = CW'(1);
        end else if (cfg_x > MAX_N) begin
            n_eff = MAX_N;
        end else begin
            n_eff = cfg_x;
        end
        last = (CW'(pos) >= (n_eff - CW'(1)));
    end

    always_comb begin
        if (r_s1_fwd) begin
            cur_word = r_s1_fwd_word;
        end else if (r_s1_zero) begin
            cur_word = '0;
        end else begin
            cur_word = r_rdata;
        end
        sum = ttfd_pkg::SUM_W'(r_s1_pix) + ttfd_pkg::SUM_W'(cur_word[7:0])
            + ttfd_pkg::SUM_W'(cur_word[15:8]);
        avg = ttfd_pkg::div3(sum);
        wr_word = r_s1_older ? {avg, cur_word[7:0]} : {cur_word[15:8], avg};
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rdata <= mem[pos];
        end
        if (s1_move) begin
            mem[r_s1_addr] <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes <= ttfd_pkg::FRAME_BYTES_RESET;
            r_byte_pos    <= '0;
            r_newest      <= 1'b0;
            r_fill        <= '0;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_frame_bytes <= pwdata[ttfd_pkg::CFG_W-1:0];
            end
            if (in_acc) begin
                r_byte_pos <= last ? '0 : pos + PW'(1);
                if (last) begin
                    r_newest <= ~r_newest;
                end
            end
            if (s1_move && ((PW + 1)'(r_s1_addr) >= r_fill)) begin
                r_fill <= (PW + 1)'(r_s1_addr) + (PW + 1)'(1);
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_addr     <= pos;
            r_s1_pix      <= i_pixel_in;
            r_s1_last     <= last;
            r_s1_older    <= ~r_newest;
            r_s1_zero     <= ((PW + 1)'(pos) >= r_fill);
            r_s1_fwd      <= s1_move && (r_s1_addr == pos);
            r_s1_fwd_word <= wr_word;
        end
        if (s1_move) begin
            r_pixel_out  <= avg;
            r_frame_last <= r_s1_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pixel_out  = r_pixel_out;
    assign o_frame_last = r_frame_last;

endmodule

// ----- rtl/core/ttfd_chk.sv -----
// Port-level checker for the temporal denoise core, bound to the top level
`timescale 1ns / 1ps
`include "temporal_three_frame_denoise_core_macros.svh"

module ttfd_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [ttfd_pkg::PIX_W-1:0]    o_pixel_out,
    input logic                          o_frame_last,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [ttfd_pkg::PADDR_W-1:0]  paddr,
    input logic [ttfd_pkg::DATA_W-1:0]   pwdata,
    input logic [ttfd_pkg::DATA_W-1:0]   prdata,
    input logic                          pready
);

    logic                          in_acc;
    logic                          out_stall;
    logic                          cfg_sel;
    logic                          cfg_hit;
    logic                          rd_match;
    logic [ttfd_pkg::PIX_W:0]      out_beat;
    logic [ttfd_pkg::CFG_W-1:0]    r_wr_val;

    assign in_acc    = i_valid && o_ready;
    assign out_stall = o_valid && !i_ready;
    assign out_beat  = {o_pixel_out, o_frame_last};
    assign cfg_sel   = (paddr[2] == ttfd_pkg::REG_FRAME_BYTES);
    assign cfg_hit   = psel && penable && pwrite && cfg_sel;
    assign rd_match  = !cfg_sel || (prdata[ttfd_pkg::CFG_W-1:0] == r_wr_val);

    always_ff @(posedge i_clk) begin
        r_wr_val <= pwdata[ttfd_pkg::CFG_W-1:0];
    end

    `TTFD_ASSERT_RST(a_rst_clears_out, !i_rst_n |=> !o_valid, "output beat valid after reset")
    `TTFD_ASSERT(a_pready_high, pready, "pready dropped")
    `TTFD_ASSERT(a_out_hold, out_stall |=> o_valid && $stable(out_beat), "held beat changed")
    `TTFD_ASSERT(a_beat_reaches_out, in_acc |=> ##1 o_valid, "accepted beat lost")
    `TTFD_ASSERT(a_cfg_readback, cfg_hit |=> rd_match, "frame_bytes readback mismatch")

endmodule

bind temporal_three_frame_denoise_core ttfd_chk u_ttfd_chk (.*);

// ----- bench/temporal_three_frame_denoise_core_tb.sv -----
// Self-checking bench for the three-frame temporal denoise core
`timescale 1ns / 1ps

module temporal_three_frame_denoise_core_tb;

    localparam int MAX_BYTES     = 65536;
    localparam int TARGET_BEATS  = 1850;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_MIN_BEAT = 300;
    localparam int HOLD_MIN_PEND = 40;
    localparam logic [ttfd_pkg::PADDR_W-1:0] FRAME_BYTES_ADDR =
        {ttfd_pkg::REG_FRAME_BYTES, 2'b00};

    typedef logic [ttfd_pkg::CFG_W-1:0]  t_cfg;
    typedef logic [ttfd_pkg::DATA_W-1:0] t_data;

    typedef struct packed {
        ttfd_pkg::t_pixel pixel;
        logic             start;
    } t_raw_beat;

    typedef struct packed {
        ttfd_pkg::t_pixel pixel;
        logic             last;
    } t_filt_beat;

    logic                               i_clk         = 1'b0;
    logic                               i_rst_n       = 1'b0;
    logic                               i_valid       = 1'b0;
    logic [ttfd_pkg::PIX_W-1:0]         i_pixel_in    = '0;
    logic                               i_frame_start = 1'b0;
    logic                               i_ready       = 1'b0;
    logic                               psel          = 1'b0;
    logic                               penable       = 1'b0;
    logic                               pwrite        = 1'b0;
    logic [ttfd_pkg::PADDR_W-1:0]       paddr         = '0;
    logic [ttfd_pkg::DATA_W-1:0]        pwdata        = '0;
    logic                               o_ready;
    logic                               o_valid;
    logic [ttfd_pkg::PIX_W-1:0]         o_pixel_out;
    logic                               o_frame_last;
    logic [ttfd_pkg::DATA_W-1:0]        prdata;
    logic                               pready;

    bit [7:0]            filt_frames [0:2*MAX_BYTES-1];
    int unsigned         filt_pos;
    bit                  filt_slot;
    t_cfg                filt_frame_bytes = ttfd_pkg::FRAME_BYTES_RESET;

    t_raw_beat           raw_q [$];
    t_filt_beat          filt_q [$];
    t_raw_beat           tx_beat;
    t_filt_beat          rx_exp;

    bit                  tx_burst;
    bit                  rx_burst;
    bit                  hold_done;
    int unsigned         tx_gap;
    int unsigned         rx_wait;
    int unsigned         rx_draw;
    int unsigned         rx_count;
    int unsigned         idle_cycles;
    int unsigned         err_count;
    int unsigned         n_settings;
    int unsigned         n_pushed;
    int unsigned         gen_pos;

    temporal_three_frame_denoise_core #(
        .MAX_FRAME_BYTES(MAX_BYTES)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel_in   (i_pixel_in),
        .i_frame_start(i_frame_start),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pixel_out  (o_pixel_out),
        .o_frame_last (o_frame_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned eff_frame_bytes(input t_cfg cfg);
        if (cfg == 0) return 1;
        if (cfg > MAX_BYTES) return MAX_BYTES;
        return 32'(cfg);
    endfunction

    function automatic int unsigned draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic void filter_pixel(input ttfd_pkg::t_pixel pix, input logic start);
        int unsigned n;
        int unsigned p;
        int unsigned newer;
        int unsigned older;
        int unsigned sum;
        t_filt_beat  res;
        n = eff_frame_bytes(filt_frame_bytes);
        if (start) filt_pos = 0;
        p = (filt_pos >= MAX_BYTES) ? MAX_BYTES - 1 : filt_pos;
        newer = {filt_slot, p[15:0]};
        older = {~filt_slot, p[15:0]};
        sum = pix + filt_frames[newer] + filt_frames[older];
        res.pixel = ttfd_pkg::t_pixel'(sum / 3);
        res.last = (p >= n - 1);
        filt_frames[older] = res.pixel;
        if (res.last) begin
            filt_pos = 0;
            filt_slot = ~filt_slot;
        end else begin
            filt_pos = p + 1;
        end
        filt_q.push_back(res);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (i_valid && o_ready) filter_pixel(i_pixel_in, i_frame_start);
            if (!i_valid || o_ready) begin
                if (tx_gap != 0) begin
                    i_valid <= 1'b0;
                    tx_gap <= tx_gap - 1;
                end else if (raw_q.size() != 0) begin
                    tx_beat = raw_q.pop_front();
                    i_valid <= 1'b1;
                    i_pixel_in <= tx_beat.pixel;
                    i_frame_start <= tx_beat.start;
                    tx_gap <= draw_wait(tx_burst);
                    if ($urandom_range(0, 31) == 0) tx_burst <= ~tx_burst;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_wait <= 0;
        end else if (o_valid && i_ready) begin
            if (filt_q.size() == 0) begin
                $error("output beat with nothing pending: pixel_out %0d", o_pixel_out);
                err_count++;
            end else begin
                rx_exp = filt_q.pop_front();
                if (o_pixel_out !== rx_exp.pixel) begin
                    $error("pixel_out mismatch: expected %0d, actual %0d",
                           rx_exp.pixel, o_pixel_out);
                    err_count++;
                end
                if (o_frame_last !== rx_exp.last) begin
                    $error("frame_last mismatch: expected %0d, actual %0d",
                           rx_exp.last, o_frame_last);
                    err_count++;
                end
            end
            rx_count++;
            if (!hold_done && rx_count >= HOLD_MIN_BEAT && raw_q.size() >= HOLD_MIN_PEND) begin
                hold_done = 1'b1;
                i_ready <= 1'b0;
                rx_wait <= HOLD_CYCLES - 1;
            end else begin
                rx_draw = draw_wait(rx_burst);
                if (rx_draw == 0) begin
                    i_ready <= 1'b1;
                end else begin
                    i_ready <= 1'b0;
                    rx_wait <= rx_draw - 1;
                end
                if ($urandom_range(0, 31) == 0) rx_burst <= ~rx_burst;
            end
        end else if (!i_ready) begin
            if (rx_wait == 0) i_ready <= 1'b1;
            else rx_wait <= rx_wait - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_beat(input ttfd_pkg::t_pixel pix, input logic start);
        raw_q.push_back('{pixel: pix, start: start});
        n_pushed++;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (raw_q.size() != 0 || i_valid || filt_q.size() != 0);
    endtask

    task automatic write_frame_bytes(input t_cfg value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= FRAME_BYTES_ADDR;
        pwdata <= t_data'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        filt_frame_bytes = value;
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== t_data'(value)) begin
            $error("frame_bytes readback mismatch: expected %0d, actual %0d", value, prdata);
            err_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        n_settings++;
        @(negedge i_clk);
    endtask

    task automatic push_frames(input int unsigned count);
        int unsigned      n;
        int unsigned      r;
        logic             start;
        ttfd_pkg::t_pixel pix;
        n = eff_frame_bytes(filt_frame_bytes);
        for (int k = 0; k < count; k++) begin
            start = (gen_pos == 0);
            r = $urandom_range(0, 99);
            if (r < 3) start = 1'b1;
            else if (r < 5) start = 1'b0;
            if (start) gen_pos = 0;
            r = $urandom_range(0, 19);
            if (r == 0) pix = '0;
            else if (r == 1) pix = '1;
            else pix = ttfd_pkg::t_pixel'($urandom_range(0, 255));
            push_beat(pix, start);
            if (gen_pos >= n - 1) gen_pos = 0;
            else gen_pos++;
        end
    endtask

    initial begin
        t_cfg size;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_beat(8'd255, 1'b1);
        push_beat(8'd255, 1'b0);
        push_beat(8'd0, 1'b0);
        push_beat(8'd128, 1'b1);
        push_beat(8'd1, 1'b0);
        push_beat(8'd254, 1'b0);
        drain();

        write_frame_bytes(17'd1);
        for (int k = 0; k < 6; k++) push_beat(8'd255, k[0]);
        drain();

        write_frame_bytes(17'd0);
        push_beat(8'd0, 1'b1);
        push_beat(8'd255, 1'b0);
        drain();

        write_frame_bytes(17'd16);
        for (int k = 0; k < 7; k++) push_beat(k[0] ? 8'd255 : 8'd170, k == 0);
        drain();

        write_frame_bytes(17'd4);
        push_beat(8'd85, 1'b0);
        push_beat(8'd255, 1'b0);
        drain();

        write_frame_bytes(17'h1FFFF);
        push_beat(8'd255, 1'b0);
        push_beat(8'd0, 1'b0);

        gen_pos = 0;
        while (n_pushed < TARGET_BEATS) begin
            drain();
            case ($urandom_range(0, 9))
                0: size = 17'd1;
                1: size = 17'd0;
                2: size = 17'h1FFFF;
                3: size = 17'd65536;
                9: size = t_cfg'($urandom_range(41, 300));
                default: size = t_cfg'($urandom_range(2, 40));
            endcase
            write_frame_bytes(size);
            push_frames($urandom_range(60, 200));
        end
        drain();
        repeat (8) @(posedge i_clk);

        $display("checked %0d filtered beats over %0d frame size settings", rx_count, n_settings);
        $display("sizes 0..131071, mid-frame restarts and shrinks, long receiver hold-off: %0d",
                 hold_done);
        if (err_count == 0 && filt_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
